[hw/rtl/rarmb_pkg.sv]
// Package for the bucketed range-add / range-min block.
// Types and constants shared by the channel interfaces and all modules.
`timescale 1ns / 1ps
`default_nettype none
package rarmb_pkg;
  localparam int unsigned IdxW = 10;
  localparam int unsigned DataW = 32;

  localparam logic OpAdd = 1'b0;
  localparam logic OpMin = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [IdxW-1:0]  start_index;
    logic [IdxW-1:0]  end_index;
    logic [DataW-1:0] addend;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] range_minimum;
  } rsp_t;
endpackage
`default_nettype wire

[hw/rtl/rarmb_req_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on rarmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rarmb_req_if;
  logic valid;
  logic ready;
  logic operation;
  logic [rarmb_pkg::IdxW-1:0] start_index;
  logic [rarmb_pkg::IdxW-1:0] end_index;
  logic signed [rarmb_pkg::DataW-1:0] addend;
  modport source (output valid, operation, start_index, end_index, addend, input ready);
  modport sink (input valid, operation, start_index, end_index, addend, output ready);
endinterface

interface rarmb_rsp_if;
  logic valid;
  logic ready;
  logic signed [rarmb_pkg::DataW-1:0] range_minimum;
  modport source (output valid, range_minimum, input ready);
  modport sink (input valid, range_minimum, output ready);
endinterface
`default_nettype wire

[hw/rtl/rarmb_front.sv]
// Front end: accepts request beats, clamps and orders the indices,
// and holds them in a two-entry queue for the back end. Depends on rarmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rarmb_front #(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  rarmb_req_if.sink req,
  output rarmb_pkg::req_t q_data,
  output logic q_valid,
  input  wire logic q_pop
);
  localparam logic [rarmb_pkg::IdxW:0] LastIdx = (rarmb_pkg::IdxW+1)'(NUM_ELEMENTS - 1);

  rarmb_pkg::req_t entry [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic [rarmb_pkg::IdxW-1:0] s_c, t_c;
  rarmb_pkg::req_t cls;
  logic push;

  always_comb begin
    s_c = ({1'b0, req.start_index} > LastIdx) ? LastIdx[rarmb_pkg::IdxW-1:0] : req.start_index;
    t_c = ({1'b0, req.end_index} > LastIdx) ? LastIdx[rarmb_pkg::IdxW-1:0] : req.end_index;
    cls.operation = req.operation;
    cls.addend = req.addend;
    if (s_c > t_c) begin
      cls.start_index = t_c;
      cls.end_index = s_c;
    end else begin
      cls.start_index = s_c;
      cls.end_index = t_c;
    end
  end

  assign req.ready = (count != 2'd2);
  assign push = req.valid && req.ready;
  assign q_valid = (count != 2'd0);
  assign q_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  a_order: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> q_data.start_index <= q_data.end_index) else $error("queue range unordered");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count overflow");
  a_nopop: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |=> count <= 2'd1) else $error("queue grew from empty by two");
endmodule
`default_nettype wire

[hw/rtl/rarmb_back.sv]
// Back end: sequencer over the element memory and bucket summary registers.
// Folds edge buckets, updates/scans elements, walks covered buckets. Depends on rarmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rarmb_back #(
  parameter int unsigned NUM_ELEMENTS = 1024,
  parameter int unsigned BUCKET_SIZE = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire rarmb_pkg::req_t q_data,
  input  wire logic q_valid,
  output logic q_pop,
  rarmb_rsp_if.source rsp
);
  localparam int unsigned NB = (NUM_ELEMENTS + BUCKET_SIZE - 1) / BUCKET_SIZE;
  localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int unsigned BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned DW = rarmb_pkg::DataW;
  localparam logic [DW-1:0] MaxPos = {1'b0, {(DW-1){1'b1}}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_PASS  = 4'd2;
  localparam logic [3:0] S_BKT   = 4'd3;
  localparam logic [3:0] S_OUT   = 4'd4;

  // element memory: one read and one write per cycle, registered read
  logic [DW-1:0] mem [NUM_ELEMENTS];
  logic [AW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] rd_data, wr_data;
  logic wr_en;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic [DW-1:0] bmin [NB];
  logic [DW-1:0] bpend [NB];

  logic [3:0] state;
  rarmb_pkg::req_t cur;
  logic [AW-1:0] s_idx, t_idx;
  logic [BW-1:0] sb, eb, bk;
  logic pass;                 // 0: start bucket, 1: end bucket
  logic [AW:0] ptr;           // read pointer
  logic [AW:0] p_end;         // one past last element of the bucket
  logic rv;                   // a read beat is in flight
  logic [AW-1:0] rv_addr;
  logic [DW-1:0] pend;        // pending addend being folded
  logic [DW-1:0] run_min, bkt_min;
  logic [DW-1:0] out_min;
  logic out_valid;
  logic [AW:0] clr;

  function automatic logic lt(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [AW:0] bend(input logic [BW-1:0] b);
    logic [AW+BW:0] e;
    e = (AW+BW+1)'(b + 1) * (AW+BW+1)'(BUCKET_SIZE);
    return (e > (AW+BW+1)'(NUM_ELEMENTS)) ? (AW+1)'(NUM_ELEMENTS) : e[AW:0];
  endfunction

  function automatic logic [AW:0] bstart(input logic [BW-1:0] b);
    logic [AW+BW:0] e;
    e = (AW+BW+1)'(b) * (AW+BW+1)'(BUCKET_SIZE);
    return e[AW:0];
  endfunction

  // in-range test on the element returning from memory
  logic in_rng;
  logic [DW-1:0] folded, updated;
  assign in_rng = (rv_addr >= s_idx) && (rv_addr <= t_idx);
  assign folded = rd_data + pend;
  assign updated = (in_rng && cur.operation == rarmb_pkg::OpAdd) ? folded + cur.addend : folded;
  assign wr_en = (state == S_CLEAR) || ((state == S_PASS) && rv);
  assign wr_addr = (state == S_CLEAR) ? clr[AW-1:0] : rv_addr;
  assign wr_data = (state == S_CLEAR) ? '0 : updated;
  assign rd_addr = ptr[AW-1:0];
  assign q_pop = (state == S_IDLE) && q_valid;
  assign rsp.valid = out_valid;
  assign rsp.range_minimum = out_min;

  logic [BW-1:0] pb;
  assign pb = pass ? eb : sb;
  logic [AW-1:0] qs, qt;
  assign qs = q_data.start_index[AW-1:0];
  assign qt = q_data.end_index[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      rv <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        bmin[i] <= '0;
        bpend[i] <= '0;
      end
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(NUM_ELEMENTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            s_idx <= qs;
            t_idx <= qt;
            sb <= BW'(qs / BUCKET_SIZE);
            eb <= BW'(qt / BUCKET_SIZE);
            pass <= 1'b0;
            ptr <= bstart(BW'(qs / BUCKET_SIZE));
            p_end <= bend(BW'(qs / BUCKET_SIZE));
            pend <= bpend[BW'(qs / BUCKET_SIZE)];
            run_min <= MaxPos;
            bkt_min <= MaxPos;
            rv <= 1'b0;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          // issue reads
          if (ptr != p_end) begin
            rv <= 1'b1;
            rv_addr <= ptr[AW-1:0];
            ptr <= ptr + 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (rv) begin
            if (lt(updated, bkt_min)) bkt_min <= updated;
            if (in_rng && lt(folded, run_min)) run_min <= folded;
          end
          if (ptr == p_end && rv) begin
            // last beat of this bucket is retiring now
            bpend[pb] <= '0;
            // add rescans the bucket; min only carries the pending addend over
            if (cur.operation == rarmb_pkg::OpAdd)
              bmin[pb] <= lt(updated, bkt_min) ? updated : bkt_min;
            else
              bmin[pb] <= bmin[pb] + pend;
            if (!pass && eb != sb) begin
              pass <= 1'b1;
              ptr <= bstart(eb);
              p_end <= bend(eb);
              pend <= bpend[eb];
              bkt_min <= MaxPos;
            end else begin
              bk <= sb + 1'b1;
              state <= S_BKT;
            end
          end
        end
        S_BKT: begin
          if (bk >= eb || eb == sb) begin
            state <= (cur.operation == rarmb_pkg::OpMin) ? S_OUT : S_IDLE;
          end else begin
            if (cur.operation == rarmb_pkg::OpAdd)
              bpend[bk] <= bpend[bk] + cur.addend;
            else if (lt(bmin[bk] + bpend[bk], run_min))
              run_min <= bmin[bk] + bpend[bk];
            bk <= bk + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_min <= run_min;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_single: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || rsp.ready)) |=> out_valid) else $error("result lost");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_PASS) else $error("pop without start");
  a_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PASS |-> sb <= eb) else $error("bucket order");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> $stable(out_min)) else $error("result changed while held");
endmodule
`default_nettype wire

[hw/rtl/range_add_range_min_buckets.sv]
// Top level of the bucketed range-add / range-min block.
// Depends on rarmb_pkg, rarmb_req_if/rarmb_rsp_if, rarmb_front, rarmb_back.
//
//  channel | dir | payload
//  req     | in  | operation, start_index, end_index, addend
//  rsp     | out | range_minimum (one beat per min request)
//
// After reset the element memory is cleared one entry a cycle; no request
// leaves the queue until the clear is done. The back end works on one request
// at a time: it scans the start and end buckets element by element, then walks
// the covered buckets.
// The two-entry queue keeps taking requests, until it is full, while the back
// end works or a result is stalled.
`timescale 1ns / 1ps
`default_nettype none
module range_add_range_min_buckets #(
  parameter int unsigned NUM_ELEMENTS = 1024,
  parameter int unsigned BUCKET_SIZE = 32
) (
  input wire logic clk,
  input wire logic rst,
  rarmb_req_if.sink req,
  rarmb_rsp_if.source rsp
);
  rarmb_pkg::req_t q_data;
  logic q_valid, q_pop;

  rarmb_front #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_front (
    .clk(clk), .rst(rst), .req(req), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  rarmb_back #(.NUM_ELEMENTS(NUM_ELEMENTS), .BUCKET_SIZE(BUCKET_SIZE)) u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .rsp(rsp)
  );
endmodule
`default_nettype wire
